// ===== hdl/csi_pkg.sv =====
`timescale 1ns / 1ps

package csi_pkg;

  // Axis count and datapath widths.
  localparam int AXES       = 4;
  localparam int ANG_W      = 8;
  localparam int PROD_W     = 2 * ANG_W;
  localparam int AXIS_IDX_W = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int DIV_CNT_W  = $clog2(ANG_W);

  localparam logic [ANG_W-1:0] STEP_SIZE_RESET = ANG_W'(5);

  typedef logic [ANG_W-1:0]  ang_t;
  typedef logic [PROD_W-1:0] prod_t;

  // Request kinds carried in req_type.
  typedef enum logic {
    REQ_START = 1'b0,
    REQ_TICK  = 1'b1
  } req_e;

  // Input beat.
  typedef struct packed {
    logic req_type;
    ang_t cur_a;
    ang_t cur_b;
    ang_t cur_c;
    ang_t cur_d;
    ang_t tgt_a;
    ang_t tgt_b;
    ang_t tgt_c;
    ang_t tgt_d;
  } in_beat_t;

  // Output beat.
  typedef struct packed {
    ang_t pos_a;
    ang_t pos_b;
    ang_t pos_c;
    ang_t pos_d;
    logic moving;
    logic final_step;
  } out_beat_t;

  // Divider request and response.
  typedef struct packed {
    logic  start;
    prod_t dividend;
    ang_t  divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    ang_t quot;
  } div_rsp_t;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_MAXF   = 8'b0000_0010,
    ST_SDIV   = 8'b0000_0100,
    ST_SWAIT  = 8'b0000_1000,
    ST_MUL    = 8'b0001_0000,
    ST_IDIV   = 8'b0010_0000,
    ST_IWAIT  = 8'b0100_0000,
    ST_RESULT = 8'b1000_0000
  } state_e;

endpackage

// ===== hdl/coordinated_servo_interpolator_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// in        input      in_valid_i / in_ready_o     in_data_i  (csi_pkg::in_beat_t)
// out       output     out_valid_o / out_ready_i   out_data_o (csi_pkg::out_beat_t)
// cfg       input      cfg_we_i                    cfg_data_i (step_size)
//
// A tick beat updates the axes at acceptance; the result is registered in ST_RESULT once the
// output register is free. A start beat uses the one shared divider: one division for
// the step count, then one multiply and one division per axis. With no travel or a zero
// step size a start skips the divisions.
// Reset clears positions, increments, directions and step count, and sets step_size to 5.
// in_ready_o is high only while idle; a result blocked by a full output register waits.
module coordinated_servo_interpolator_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  csi_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output csi_pkg::out_beat_t  out_data_o,
  input  logic                cfg_we_i,
  input  csi_pkg::ang_t       cfg_data_i
);

  csi_pkg::state_e state_q, state_d;

  csi_pkg::ang_t pos_q  [csi_pkg::AXES];
  csi_pkg::ang_t pos_d  [csi_pkg::AXES];
  csi_pkg::ang_t inc_q  [csi_pkg::AXES];
  csi_pkg::ang_t inc_d  [csi_pkg::AXES];
  logic          down_q [csi_pkg::AXES];
  logic          down_d [csi_pkg::AXES];
  csi_pkg::ang_t diff_q [csi_pkg::AXES];
  csi_pkg::ang_t diff_d [csi_pkg::AXES];

  csi_pkg::ang_t                  steps_q, steps_d;
  csi_pkg::ang_t                  step_q, step_d;
  csi_pkg::ang_t                  big_q, big_d;
  csi_pkg::prod_t                 prod_q, prod_d;
  logic [csi_pkg::AXIS_IDX_W-1:0] idx_q, idx_d;
  logic                           fin_q, fin_d;
  logic                           out_valid_q, out_valid_d;
  csi_pkg::out_beat_t             out_q, out_d;

  csi_pkg::ang_t     cur_in [csi_pkg::AXES];
  csi_pkg::ang_t     tgt_in [csi_pkg::AXES];
  csi_pkg::ang_t     max_diff;
  csi_pkg::div_req_t div_req;
  csi_pkg::div_rsp_t div_rsp;

  // Unpack the per-axis input fields.
  assign cur_in[0] = in_data_i.cur_a;
  assign cur_in[1] = in_data_i.cur_b;
  assign cur_in[2] = in_data_i.cur_c;
  assign cur_in[3] = in_data_i.cur_d;
  assign tgt_in[0] = in_data_i.tgt_a;
  assign tgt_in[1] = in_data_i.tgt_b;
  assign tgt_in[2] = in_data_i.tgt_c;
  assign tgt_in[3] = in_data_i.tgt_d;

  // Largest travel over the registered differences.
  always_comb begin
    max_diff = '0;
    for (int i = 0; i < csi_pkg::AXES; i++) begin
      if (diff_q[i] > max_diff) begin
        max_diff = diff_q[i];
      end
    end
  end

  csi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o = (state_q == csi_pkg::ST_IDLE);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    inc_d       = inc_q;
    down_d      = down_q;
    diff_d      = diff_q;
    steps_d     = steps_q;
    step_d      = step_q;
    big_d       = big_q;
    prod_d      = prod_q;
    idx_d       = idx_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    div_req          = '0;
    div_req.dividend = prod_q;
    div_req.divisor  = big_q;

    if (cfg_we_i) begin
      step_d = cfg_data_i;
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      csi_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          fin_d = 1'b0;
          if (in_data_i.req_type == csi_pkg::REQ_TICK) begin
            // Advance every axis by its increment while steps remain.
            if (steps_q != '0) begin
              for (int i = 0; i < csi_pkg::AXES; i++) begin
                pos_d[i] = down_q[i] ? (pos_q[i] - inc_q[i]) : (pos_q[i] + inc_q[i]);
              end
              steps_d = steps_q - 1'b1;
              fin_d   = (steps_q == csi_pkg::ANG_W'(1));
            end
            state_d = csi_pkg::ST_RESULT;
          end else begin
            // Load positions, directions and absolute travel.
            for (int i = 0; i < csi_pkg::AXES; i++) begin
              pos_d[i] = cur_in[i];
              if (tgt_in[i] > cur_in[i]) begin
                diff_d[i] = tgt_in[i] - cur_in[i];
                down_d[i] = 1'b0;
              end else begin
                diff_d[i] = cur_in[i] - tgt_in[i];
                down_d[i] = 1'b1;
              end
            end
            state_d = csi_pkg::ST_MAXF;
          end
        end
      end
      csi_pkg::ST_MAXF: begin
        big_d = max_diff;
        if (max_diff == '0 || step_q == '0) begin
          steps_d = '0;
          for (int i = 0; i < csi_pkg::AXES; i++) begin
            inc_d[i] = '0;
          end
          state_d = csi_pkg::ST_RESULT;
        end else begin
          state_d = csi_pkg::ST_SDIV;
        end
      end
      csi_pkg::ST_SDIV: begin
        // Step count is largest travel over step size.
        div_req.start    = 1'b1;
        div_req.dividend = csi_pkg::PROD_W'(big_q);
        div_req.divisor  = step_q;
        state_d          = csi_pkg::ST_SWAIT;
      end
      csi_pkg::ST_SWAIT: begin
        if (div_rsp.done) begin
          steps_d = div_rsp.quot;
          idx_d   = '0;
          state_d = csi_pkg::ST_MUL;
        end
      end
      csi_pkg::ST_MUL: begin
        prod_d  = csi_pkg::PROD_W'(step_q) * csi_pkg::PROD_W'(diff_q[idx_q]);
        state_d = csi_pkg::ST_IDIV;
      end
      csi_pkg::ST_IDIV: begin
        // Increment is step size times travel over largest travel.
        div_req.start = 1'b1;
        state_d       = csi_pkg::ST_IWAIT;
      end
      csi_pkg::ST_IWAIT: begin
        if (div_rsp.done) begin
          inc_d[idx_q] = div_rsp.quot;
          if (idx_q == csi_pkg::AXIS_IDX_W'(csi_pkg::AXES - 1)) begin
            state_d = csi_pkg::ST_RESULT;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = csi_pkg::ST_MUL;
          end
        end
      end
      csi_pkg::ST_RESULT: begin
        // Hand the beat to the output register once it is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d      = 1'b1;
          out_d.pos_a      = pos_q[0];
          out_d.pos_b      = pos_q[1];
          out_d.pos_c      = pos_q[2];
          out_d.pos_d      = pos_q[3];
          out_d.moving     = (steps_q != '0);
          out_d.final_step = fin_q;
          state_d          = csi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = csi_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= csi_pkg::ST_IDLE;
      steps_q     <= '0;
      step_q      <= csi_pkg::STEP_SIZE_RESET;
      idx_q       <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < csi_pkg::AXES; i++) begin
        pos_q[i]  <= '0;
        inc_q[i]  <= '0;
        down_q[i] <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      steps_q     <= steps_d;
      step_q      <= step_d;
      idx_q       <= idx_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      inc_q       <= inc_d;
      down_q      <= down_d;
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    big_q  <= big_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/csi_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The caller guarantees that the
// upper half of the dividend is below the divisor, so the quotient fits ANG_W bits.
module csi_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csi_pkg::div_req_t req_i,
  output csi_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [csi_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  csi_pkg::ang_t                 rem_q, rem_d;
  csi_pkg::ang_t                 quo_q, quo_d;
  csi_pkg::ang_t                 dvs_q, dvs_d;

  logic [csi_pkg::ANG_W:0] shifted;
  logic [csi_pkg::ANG_W:0] diff;
  logic                    fits;

  // Shift the next dividend bit in and trial-subtract the divisor.
  assign shifted = {rem_q, quo_q[csi_pkg::ANG_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = (shifted >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.dividend[csi_pkg::PROD_W-1:csi_pkg::ANG_W];
      quo_d  = req_i.dividend[csi_pkg::ANG_W-1:0];
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[csi_pkg::ANG_W-1:0] : shifted[csi_pkg::ANG_W-1:0];
      quo_d = {quo_q[csi_pkg::ANG_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == csi_pkg::DIV_CNT_W'(csi_pkg::ANG_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule
